// ===== rtl/pic_pkg.sv =====
// Package with the shared constants, function codes and control types of the capture block.
`timescale 1ns / 1ps

package pic_pkg;

  localparam int DEPTH_DEFAULT      = 256;
  localparam int COUNT_BITS_DEFAULT = 16;

  localparam int FUNC_W       = 2;
  localparam int INDEX_W      = 8;
  localparam int EDGE_COUNT_W = 9;
  localparam int READ_DATA_W  = 16;
  localparam int TIMEOUT_W    = 16;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'hFFFF;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_EDGE  = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_t;

  // Request from the control logic to the interval store for one word.
  typedef struct packed {
    logic wr;
    logic rd;
    logic rd_in_range;
    logic clr;
  } store_req_t;

endpackage

// ===== rtl/pic_store.sv =====
// Interval store: a synchronous memory of captured intervals with per-entry valid bits.
`timescale 1ns / 1ps

module pic_store #(
  parameter int DEPTH      = pic_pkg::DEPTH_DEFAULT,
  parameter int COUNT_BITS = pic_pkg::COUNT_BITS_DEFAULT,
  localparam int IDX_W     = $clog2(DEPTH),
  localparam int CNT_W     = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  pic_pkg::store_req_t   req,
  input  logic [IDX_W-1:0]      wr_addr,
  input  logic [COUNT_BITS-1:0] wr_data,
  input  logic [IDX_W-1:0]      rd_addr,
  input  logic [CNT_W-1:0]      clr_count,
  input  logic                  hold,
  output logic [COUNT_BITS-1:0] rd_data,
  output logic                  rd_hit
);

  logic [COUNT_BITS-1:0] mem [DEPTH];
  logic [DEPTH-1:0]      valid;
  logic [COUNT_BITS-1:0] mem_q;
  logic                  hit_q;

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[wr_addr] <= wr_data;
    end
    if (req.rd && !hold) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_q <= 1'b0;
    end else if (req.rd && !hold) begin
      hit_q <= req.rd_in_range && valid[rd_addr];
    end
  end

  // A clear invalidates only the entries below the current fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (req.clr) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (CNT_W'(i) < clr_count) begin
          valid[i] <= 1'b0;
        end
      end
    end else if (req.wr) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = mem_q;
  assign rd_hit  = hit_q;

endmodule

// ===== rtl/pulse_interval_capture.sv =====
// Top level of the pulse interval capture block.
`timescale 1ns / 1ps
// Usage: each word on the input channel (in_valid/in_ready) carries a function
// code and an entry index. A tick advances the interval counter or, at the
// timeout, restarts it and ends the transmission; an edge stores the counter
// in the next buffer entry (or sets overflow if full) and restarts it, a read
// returns one stored interval and a clear empties the buffer and the status.
// Every input word yields exactly one result word on the output channel
// (out_valid/out_ready) with the status after that word's update. Each word
// passes the memory stage (synchronous read of the interval memory) and then
// the output register. Throughput is one word per cycle while the receiver
// does not stall; the single memory port serves one access per word, and state
// updates complete in the acceptance cycle. When the receiver stalls, the
// output register and the memory stage hold their words; the input keeps being
// accepted until both are occupied. Reset clears the counter, the status, all
// valid bits and the pipeline, and sets the timeout to its maximum. No
// clearing pass is needed after reset. The timeout register may be written
// through cfg_wr_en/cfg_wr_data while the block is idle.

module pulse_interval_capture #(
  parameter int DEPTH      = pic_pkg::DEPTH_DEFAULT,
  parameter int COUNT_BITS = pic_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [pic_pkg::TIMEOUT_W-1:0]      cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [pic_pkg::FUNC_W-1:0]         func,
  input  logic [pic_pkg::INDEX_W-1:0]        entry_index,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               active,
  output logic [pic_pkg::EDGE_COUNT_W-1:0]   edge_count,
  output logic [pic_pkg::READ_DATA_W-1:0]    read_data,
  output logic                               timed_out,
  output logic                               overflow
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (COUNT_BITS > pic_pkg::TIMEOUT_W) ? COUNT_BITS : pic_pkg::TIMEOUT_W;
  localparam int XI_W  = (CNT_W > pic_pkg::INDEX_W) ? CNT_W : pic_pkg::INDEX_W;
  localparam int EC_W  = (CNT_W > pic_pkg::EDGE_COUNT_W) ? CNT_W : pic_pkg::EDGE_COUNT_W;
  localparam int RD_W  = (COUNT_BITS > pic_pkg::READ_DATA_W) ? COUNT_BITS : pic_pkg::READ_DATA_W;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
  localparam logic [XI_W-1:0]  DEPTH_XI  = XI_W'(DEPTH);

  // Architectural state.
  logic [pic_pkg::TIMEOUT_W-1:0] timeout_ticks;
  logic [COUNT_BITS-1:0]         tick_counter, tick_counter_next;
  logic                          active_flag, active_flag_next;
  logic [CNT_W-1:0]              stored_edges, stored_edges_next;
  logic                          dropped_flag, dropped_flag_next;
  logic                          tout_next;

  // Memory stage and output register.
  logic                          s1_valid;
  logic                          s1_active, s1_tout, s1_dropped, s1_read;
  logic [CNT_W-1:0]              s1_count;
  logic                          out_full;
  logic                          o_active, o_tout, o_dropped;
  logic [pic_pkg::EDGE_COUNT_W-1:0] o_count;
  logic [pic_pkg::READ_DATA_W-1:0]  o_data;

  logic                          accept, s1_advance;
  pic_pkg::func_t                func_code;
  pic_pkg::store_req_t           req;
  logic [XI_W-1:0]               idx_ext;
  logic [CMP_W-1:0]              cnt_ext, tmo_ext;
  logic [COUNT_BITS-1:0]         mem_rd_data;
  logic                          mem_rd_hit;
  logic [EC_W-1:0]               count_ext;
  logic [RD_W-1:0]               data_ext;

  assign s1_advance = s1_valid && (!out_full || out_ready);
  assign in_ready   = !s1_valid || !out_full || out_ready;
  assign accept     = in_valid && in_ready;
  assign func_code  = pic_pkg::func_t'(func);
  assign idx_ext    = XI_W'(entry_index);
  assign cnt_ext    = CMP_W'(tick_counter);
  assign tmo_ext    = CMP_W'(timeout_ticks);

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= pic_pkg::TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      timeout_ticks <= cfg_wr_data;
    end
  end

  always_comb begin
    tick_counter_next = tick_counter;
    active_flag_next  = active_flag;
    stored_edges_next = stored_edges;
    dropped_flag_next = dropped_flag;
    tout_next         = 1'b0;
    req               = '0;
    case (func_code)
      pic_pkg::FUNC_TICK: begin
        if (cnt_ext >= tmo_ext || tick_counter == '1) begin
          tick_counter_next = '0;
          if (active_flag) begin
            active_flag_next  = 1'b0;
            stored_edges_next = '0;
            tout_next         = 1'b1;
          end
        end else begin
          tick_counter_next = tick_counter + COUNT_BITS'(1);
        end
      end
      pic_pkg::FUNC_EDGE: begin
        if (stored_edges < DEPTH_CNT) begin
          req.wr            = accept;
          stored_edges_next = stored_edges + CNT_W'(1);
        end else begin
          dropped_flag_next = 1'b1;
        end
        tick_counter_next = '0;
        active_flag_next  = 1'b1;
      end
      pic_pkg::FUNC_READ: begin
        req.rd          = accept;
        req.rd_in_range = idx_ext < DEPTH_XI;
      end
      pic_pkg::FUNC_CLEAR: begin
        req.clr           = accept;
        active_flag_next  = 1'b0;
        stored_edges_next = '0;
        dropped_flag_next = 1'b0;
      end
      default: begin
        tick_counter_next = tick_counter;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_counter <= '0;
      active_flag  <= 1'b0;
      stored_edges <= '0;
      dropped_flag <= 1'b0;
    end else if (accept) begin
      tick_counter <= tick_counter_next;
      active_flag  <= active_flag_next;
      stored_edges <= stored_edges_next;
      dropped_flag <= dropped_flag_next;
    end
  end

  pic_store #(
    .DEPTH      (DEPTH),
    .COUNT_BITS (COUNT_BITS)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .wr_addr   (stored_edges[IDX_W-1:0]),
    .wr_data   (tick_counter),
    .rd_addr   (idx_ext[IDX_W-1:0]),
    .clr_count (stored_edges),
    .hold      (1'b0),
    .rd_data   (mem_rd_data),
    .rd_hit    (mem_rd_hit)
  );

  // The memory stage: status of the word whose memory read is under way.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_active  <= active_flag_next;
      s1_count   <= stored_edges_next;
      s1_tout    <= tout_next;
      s1_dropped <= dropped_flag_next;
      s1_read    <= func_code == pic_pkg::FUNC_READ;
    end
  end

  assign count_ext = EC_W'(s1_count);
  assign data_ext  = (s1_read && mem_rd_hit) ? RD_W'(mem_rd_data) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (s1_advance) begin
      out_full <= 1'b1;
    end else if (out_ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      o_active  <= s1_active;
      o_count   <= count_ext[pic_pkg::EDGE_COUNT_W-1:0];
      o_data    <= data_ext[pic_pkg::READ_DATA_W-1:0];
      o_tout    <= s1_tout;
      o_dropped <= s1_dropped;
    end
  end

  assign out_valid  = out_full;
  assign active     = o_active;
  assign edge_count = o_count;
  assign read_data  = o_data;
  assign timed_out  = o_tout;
  assign overflow   = o_dropped;

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the pulse interval capture block under random idling.
`timescale 1ns / 1ps

module testbench;

  localparam int BUFFER_DEPTH   = pic_pkg::DEPTH_DEFAULT;
  localparam int INDEX_BITS     = pic_pkg::INDEX_W;
  localparam int TIMEOUT_BITS   = pic_pkg::TIMEOUT_W;
  localparam int PIPE_LATENCY   = 2;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int QUEUE_AHEAD    = 4;
  localparam int PRESSURE_AT    = 300;
  localparam int PRESSURE_HOLD  = 80;

  typedef struct {
    pic_pkg::func_t              op;
    logic [pic_pkg::INDEX_W-1:0] index;
  } word_t;

  typedef struct {
    logic                             active;
    logic [pic_pkg::EDGE_COUNT_W-1:0] edge_count;
    logic [pic_pkg::READ_DATA_W-1:0]  read_data;
    logic                             timed_out;
    logic                             overflow;
  } status_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_wr_en = 1'b0;
  logic [pic_pkg::TIMEOUT_W-1:0]    cfg_wr_data = '0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [pic_pkg::FUNC_W-1:0]       func = pic_pkg::FUNC_TICK;
  logic [pic_pkg::INDEX_W-1:0]      entry_index = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic                             active;
  logic [pic_pkg::EDGE_COUNT_W-1:0] edge_count;
  logic [pic_pkg::READ_DATA_W-1:0]  read_data;
  logic                             timed_out;
  logic                             overflow;

  pulse_interval_capture i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .entry_index (entry_index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .active      (active),
    .edge_count  (edge_count),
    .read_data   (read_data),
    .timed_out   (timed_out),
    .overflow    (overflow)
  );

  initial forever #1 clk = ~clk;

  // Shadow of the capture state, advanced once per accepted word.
  logic [pic_pkg::TIMEOUT_W-1:0]          tmo_setting = pic_pkg::TIMEOUT_RESET;
  logic [pic_pkg::COUNT_BITS_DEFAULT-1:0] interval_count = '0;
  logic                                   in_transmission = 1'b0;
  int                                     stored_count = 0;
  logic                                   edge_dropped = 1'b0;
  logic [pic_pkg::READ_DATA_W-1:0]        interval_mem [BUFFER_DEPTH];
  bit                                     interval_held [BUFFER_DEPTH];
  // Entries below this index have been written at least once.
  int                                     written_top = 0;

  word_t   pending_words [$];
  status_t expected_status [$];
  status_t predicted;
  word_t   next_word;

  bit word_taken = 1'b0;
  int send_gap = 0;
  int sender_calm = 0;
  int hold_left = 0;
  int receiver_calm = 0;
  bit pressure_done = 1'b0;
  int stall_cycles = 0;

  int words_planned = 0;
  int words_accepted = 0;
  int results_seen = 0;
  int mismatches = 0;
  int settings_used = 0;
  int n_edges = 0;
  int n_reads = 0;
  int n_clears = 0;
  int n_timeouts = 0;
  int n_drops = 0;

  function automatic status_t capture_status(input pic_pkg::func_t op,
                                             input logic [pic_pkg::INDEX_W-1:0] idx);
    status_t s;
    s.read_data = '0;
    s.timed_out = 1'b0;
    case (op)
      pic_pkg::FUNC_TICK: begin
        if (interval_count >= tmo_setting || &interval_count) begin
          interval_count = '0;
          if (in_transmission) begin
            in_transmission = 1'b0;
            stored_count = 0;
            s.timed_out = 1'b1;
            n_timeouts++;
          end
        end else begin
          interval_count = interval_count + 1'b1;
        end
      end
      pic_pkg::FUNC_EDGE: begin
        n_edges++;
        if (stored_count < BUFFER_DEPTH) begin
          interval_mem[stored_count] = interval_count;
          interval_held[stored_count] = 1'b1;
          stored_count++;
          if (stored_count > written_top) written_top = stored_count;
        end else begin
          edge_dropped = 1'b1;
          n_drops++;
        end
        interval_count = '0;
        in_transmission = 1'b1;
      end
      pic_pkg::FUNC_READ: begin
        n_reads++;
        if (interval_held[idx]) s.read_data = interval_mem[idx];
      end
      default: begin
        n_clears++;
        for (int i = 0; i < stored_count; i++) begin
          interval_mem[i] = '0;
          interval_held[i] = 1'b0;
        end
        in_transmission = 1'b0;
        stored_count = 0;
        edge_dropped = 1'b0;
      end
    endcase
    s.active = in_transmission;
    s.edge_count = stored_count[pic_pkg::EDGE_COUNT_W-1:0];
    s.overflow = edge_dropped;
    return s;
  endfunction

  // Mostly short gaps, a few long ones, and now and then a calm stretch with none.
  function automatic int pick_idle(inout int calm);
    int roll;
    roll = $urandom_range(0, 99);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if (roll < 2) begin
      calm = $urandom_range(30, 60);
      return 0;
    end
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_taken) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_words.size() > 0) begin
        next_word = pending_words.pop_front();
        in_valid    <= 1'b1;
        func        <= next_word.op;
        entry_index <= next_word.index;
        send_gap    <= pick_idle(sender_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // The one long hold-off lets the block fill up and push back on the sender.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!pressure_done && results_seen >= PRESSURE_AT) begin
        pressure_done <= 1'b1;
        hold_left <= PRESSURE_HOLD;
      end else begin
        hold_left <= pick_idle(receiver_calm);
      end
    end
  end

  always @(posedge clk) begin
    word_taken <= in_valid && in_ready;
    if (!rst && in_valid && in_ready) begin
      expected_status.push_back(capture_status(pic_pkg::func_t'(func), entry_index));
      words_accepted++;
    end
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_status.size() == 0) begin
        $error("result word arrived with no expectation waiting");
        mismatches++;
      end else begin
        predicted = expected_status.pop_front();
        check_field("active", 16'(predicted.active), 16'(active));
        check_field("edge_count", 16'(predicted.edge_count), 16'(edge_count));
        check_field("read_data", predicted.read_data, read_data);
        check_field("timed_out", 16'(predicted.timed_out), 16'(timed_out));
        check_field("overflow", 16'(predicted.overflow), 16'(overflow));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic push_word(input pic_pkg::func_t op, input logic [pic_pkg::INDEX_W-1:0] idx);
    word_t w;
    while (pending_words.size() >= QUEUE_AHEAD) @(posedge clk);
    w.op = op;
    w.index = idx;
    pending_words.push_back(w);
    words_planned++;
  endtask

  task automatic push_ticks(input int n);
    repeat (n) push_word(pic_pkg::FUNC_TICK, INDEX_BITS'($urandom_range(0, 255)));
  endtask

  // Reads only go to entries that have been written at some point.
  task automatic push_read();
    int roll;
    roll = $urandom_range(0, 9);
    if (written_top == 0) begin
      push_word(pic_pkg::FUNC_TICK, INDEX_BITS'($urandom_range(0, 255)));
    end else if (roll < 4 && stored_count > 0) begin
      push_word(pic_pkg::FUNC_READ, INDEX_BITS'($urandom_range(0, stored_count - 1)));
    end else if (roll < 5) begin
      push_word(pic_pkg::FUNC_READ, INDEX_BITS'(written_top - 1));
    end else begin
      push_word(pic_pkg::FUNC_READ, INDEX_BITS'($urandom_range(0, written_top - 1)));
    end
  endtask

  task automatic wait_idle();
    while (pending_words.size() != 0 || in_valid || expected_status.size() != 0) @(negedge clk);
  endtask

  task automatic set_timeout(input logic [pic_pkg::TIMEOUT_W-1:0] tmo);
    wait_idle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= tmo;
    tmo_setting = tmo;
    settings_used++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_phase(input logic [pic_pkg::TIMEOUT_W-1:0] tmo, input int n_words,
                           input bit burst);
    int stop_at;
    int tick_cap;
    int roll;
    pic_pkg::func_t op;
    set_timeout(tmo);
    stop_at = words_planned + n_words;
    tick_cap = (tmo > 12) ? 12 : int'(tmo);
    if (burst) begin
      // Run the buffer past its depth so that later edges are dropped.
      repeat (BUFFER_DEPTH + 6) begin
        if ($urandom_range(0, 9) == 0) push_ticks($urandom_range(1, 5));
        push_word(pic_pkg::FUNC_EDGE, INDEX_BITS'($urandom_range(0, 255)));
      end
      push_word(pic_pkg::FUNC_READ, INDEX_BITS'(BUFFER_DEPTH - 1));
      push_word(pic_pkg::FUNC_READ, INDEX_BITS'(0));
      repeat (4) push_read();
      push_word(pic_pkg::FUNC_CLEAR, INDEX_BITS'($urandom_range(0, 255)));
    end
    while (words_planned < stop_at) begin
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        repeat ($urandom_range(1, 10)) begin
          push_ticks($urandom_range(0, tick_cap));
          push_word(pic_pkg::FUNC_EDGE, INDEX_BITS'($urandom_range(0, 255)));
        end
        if (tmo <= 40 && $urandom_range(0, 9) < 7) push_ticks(int'(tmo) + 2);
        repeat ($urandom_range(0, 3)) push_read();
      end else if (roll < 75) begin
        repeat ($urandom_range(1, 4)) push_read();
      end else if (roll < 82) begin
        push_word(pic_pkg::FUNC_CLEAR, INDEX_BITS'($urandom_range(0, 255)));
      end else begin
        op = pic_pkg::func_t'($urandom_range(0, 3));
        if (op == pic_pkg::FUNC_READ) push_read();
        else push_word(op, INDEX_BITS'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Short transmission, timeout with entries kept, clear of part of the buffer.
    set_timeout(16'd3);
    push_word(pic_pkg::FUNC_TICK, 8'hFF);
    push_word(pic_pkg::FUNC_TICK, 8'h00);
    push_word(pic_pkg::FUNC_EDGE, 8'hAA);
    push_word(pic_pkg::FUNC_EDGE, 8'h55);
    push_word(pic_pkg::FUNC_TICK, 8'h00);
    push_word(pic_pkg::FUNC_EDGE, 8'hFF);
    push_word(pic_pkg::FUNC_READ, 8'd0);
    push_word(pic_pkg::FUNC_READ, 8'd1);
    push_word(pic_pkg::FUNC_READ, 8'd2);
    push_ticks(4);
    push_word(pic_pkg::FUNC_TICK, 8'hFF);
    push_word(pic_pkg::FUNC_READ, 8'd2);
    push_word(pic_pkg::FUNC_EDGE, 8'h00);
    push_word(pic_pkg::FUNC_CLEAR, 8'hFF);
    push_word(pic_pkg::FUNC_READ, 8'd0);
    push_word(pic_pkg::FUNC_READ, 8'd2);
    push_word(pic_pkg::FUNC_CLEAR, 8'h00);
    push_word(pic_pkg::FUNC_EDGE, 8'h0F);
    push_word(pic_pkg::FUNC_TICK, 8'hF0);

    run_phase(16'd0, 80, 1'b0);
    run_phase(pic_pkg::TIMEOUT_RESET, 300, 1'b1);
    run_phase(16'd1, 100, 1'b0);
    run_phase(16'd5, 150, 1'b0);
    run_phase(TIMEOUT_BITS'($urandom_range(2, 40)), 150, 1'b0);
    run_phase(TIMEOUT_BITS'($urandom_range(8, 20)), 90, 1'b0);

    wait_idle();
    repeat (PIPE_LATENCY + 8) @(posedge clk);
    $display("Covered %0d words over %0d timeout settings: %0d edges, %0d reads, %0d clears.",
             words_accepted, settings_used, n_edges, n_reads, n_clears);
    $display("%0d transmissions ended by timeout and %0d edges were dropped on a full buffer.",
             n_timeouts, n_drops);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pic_pkg.sv
rtl/pic_store.sv
rtl/pulse_interval_capture.sv
tb/sv/testbench.sv
